// ----- rtl/core/lfrb_pkg.sv -----
`default_nettype none

package lfrb_pkg;

    localparam int RING_DEPTH = 4096;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int CNT_W      = PTR_W + 1;
    localparam int HDR_BYTES  = 4;
    localparam int HDR_IDX_W  = $clog2(HDR_BYTES);
    localparam int HDR_CNT_W  = $clog2(HDR_BYTES + 1);
    localparam int BYTE_W     = 8;
    localparam int LEN_W      = HDR_BYTES * BYTE_W;
    localparam int OUT_CNT_W  = 12;
    localparam int STATUS_W   = 3;

    typedef logic [PTR_W-1:0] ptr_t;

    localparam ptr_t PTR_LAST = PTR_W'(RING_DEPTH - 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(RING_DEPTH - 1 - HDR_BYTES);

    typedef enum logic
    {
        OP_PUSH = 1'b0,
        OP_PULL = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_PUSHED   = 3'd0,
        ST_GIVEN    = 3'd1,
        ST_NOFRAME  = 3'd2,
        ST_DROPPED  = 3'd3,
        ST_OVERSIZE = 3'd4
    } status_t;

    // Result of one item as it leaves the issue stage
    typedef struct packed
    {
        status_t status;
        logic    give;
        logic    last;
        ptr_t    used;
    } result_t;

    function automatic ptr_t ptr_inc(input ptr_t p);
        ptr_t r;
        if (p == PTR_LAST)
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    function automatic ptr_t ptr_add(input ptr_t p, input logic [HDR_CNT_W-1:0] k);
        logic [CNT_W-1:0] s;
        logic [CNT_W-1:0] r;
        s = CNT_W'(p) + CNT_W'(k);
        if (s >= CNT_W'(RING_DEPTH))
        begin
            r = s - CNT_W'(RING_DEPTH);
        end
        else
        begin
            r = s;
        end
        return r[PTR_W-1:0];
    endfunction

    function automatic ptr_t ring_used(input ptr_t tail, input ptr_t head);
        logic [CNT_W-1:0] d;
        if (tail >= head)
        begin
            d = CNT_W'(tail) - CNT_W'(head);
        end
        else
        begin
            d = CNT_W'(tail) + CNT_W'(RING_DEPTH) - CNT_W'(head);
        end
        return d[PTR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/lfrb_ram.sv -----
`default_nettype none

module lfrb_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/lfrb_ctrl.sv -----
`default_nettype none

module lfrb_ctrl (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire lfrb_pkg::op_t                op,
    input  wire logic [lfrb_pkg::BYTE_W-1:0]  in_byte,
    input  wire logic                         pipe_ready,
    input  wire logic                         rd_busy,
    output logic                              issue,
    output lfrb_pkg::result_t                 res,
    output logic                              wr_en,
    output lfrb_pkg::ptr_t                    wr_addr,
    output logic [lfrb_pkg::BYTE_W-1:0]       wr_data,
    output logic                              rd_en,
    output lfrb_pkg::ptr_t                    rd_addr,
    input  wire logic [lfrb_pkg::BYTE_W-1:0]  rd_data
);

    lfrb_pkg::ptr_t head_reg, head_next;
    lfrb_pkg::ptr_t tail_reg, tail_next;
    lfrb_pkg::ptr_t left_reg, left_next;
    logic [lfrb_pkg::HDR_CNT_W-1:0] hdr_cnt_reg, hdr_cnt_next;
    logic pf_pend_reg, pf_pend_next;
    logic [lfrb_pkg::BYTE_W-1:0] hdr_reg [lfrb_pkg::HDR_BYTES];

    lfrb_pkg::ptr_t used;
    lfrb_pkg::ptr_t need;
    logic [lfrb_pkg::LEN_W-1:0] frame_len;
    logic hdr_full;
    logic hdr_wait;
    logic give;
    logic pf_issue;

    assign used     = lfrb_pkg::ring_used(tail_reg, head_reg);
    assign hdr_full = (hdr_cnt_reg == lfrb_pkg::HDR_CNT_W'(lfrb_pkg::HDR_BYTES));

    // Length prefix is big-endian: first header byte is most significant
    always_comb
    begin
        for (int i = 0; i < lfrb_pkg::HDR_BYTES; i++)
        begin
            frame_len[lfrb_pkg::LEN_W-1-i*lfrb_pkg::BYTE_W -: lfrb_pkg::BYTE_W] = hdr_reg[i];
        end
    end

    assign need = lfrb_pkg::PTR_W'(frame_len) + lfrb_pkg::PTR_W'(lfrb_pkg::HDR_BYTES);

    // Hold a pull that must look at a header not yet fetched
    assign hdr_wait = (op == lfrb_pkg::OP_PULL) && (left_reg == '0)
                   && (used >= lfrb_pkg::PTR_W'(lfrb_pkg::HDR_BYTES)) && !hdr_full;
    assign in_ready = pipe_ready && !hdr_wait;
    assign issue    = in_valid && in_ready;

    // Background header fetch, one byte at a time, while no frame is released
    assign pf_issue = (left_reg == '0) && !hdr_full && !pf_pend_reg && !rd_busy
                   && (lfrb_pkg::PTR_W'(hdr_cnt_reg) < used);

    always_comb
    begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        left_next    = left_reg;
        hdr_cnt_next = hdr_cnt_reg;
        pf_pend_next = pf_issue;
        give         = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = tail_reg;
        wr_data      = in_byte;
        res.status   = lfrb_pkg::ST_NOFRAME;
        res.give     = 1'b0;
        res.last     = 1'b0;
        res.used     = used;

        if (pf_pend_reg)
        begin
            hdr_cnt_next = hdr_cnt_reg + lfrb_pkg::HDR_CNT_W'(1);
        end

        unique case (op)
            lfrb_pkg::OP_PUSH:
            begin
                if (used >= lfrb_pkg::PTR_LAST)
                begin
                    res.status = lfrb_pkg::ST_DROPPED;
                end
                else
                begin
                    res.status = lfrb_pkg::ST_PUSHED;
                    res.used   = used + lfrb_pkg::PTR_W'(1);
                    wr_en      = issue;
                    if (issue)
                    begin
                        tail_next = lfrb_pkg::ptr_inc(tail_reg);
                    end
                end
            end
            lfrb_pkg::OP_PULL:
            begin
                priority if (left_reg != '0)
                begin
                    give      = 1'b1;
                    left_next = left_reg - lfrb_pkg::PTR_W'(1);
                end
                else if (used < lfrb_pkg::PTR_W'(lfrb_pkg::HDR_BYTES))
                begin
                    res.status = lfrb_pkg::ST_NOFRAME;
                end
                else if (frame_len > lfrb_pkg::LEN_MAX)
                begin
                    res.status = lfrb_pkg::ST_OVERSIZE;
                end
                else if (used < need)
                begin
                    res.status = lfrb_pkg::ST_NOFRAME;
                end
                else
                begin
                    // Release the frame; header cache refills after its last byte
                    give         = 1'b1;
                    left_next    = need - lfrb_pkg::PTR_W'(1);
                    hdr_cnt_next = '0;
                end
                if (give)
                begin
                    res.status = lfrb_pkg::ST_GIVEN;
                    res.give   = 1'b1;
                    res.last   = (left_next == '0);
                    res.used   = used - lfrb_pkg::PTR_W'(1);
                    if (issue)
                    begin
                        head_next = lfrb_pkg::ptr_inc(head_reg);
                    end
                end
            end
            default:
            begin
                res.status = lfrb_pkg::ST_NOFRAME;
            end
        endcase

        if (!issue)
        begin
            left_next = left_reg;
            if (!pf_pend_reg)
            begin
                hdr_cnt_next = hdr_cnt_reg;
            end
            else
            begin
                hdr_cnt_next = hdr_cnt_reg + lfrb_pkg::HDR_CNT_W'(1);
            end
        end
    end

    assign rd_en   = (issue && give) || pf_issue;
    assign rd_addr = (issue && give) ? head_reg : lfrb_pkg::ptr_add(head_reg, hdr_cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            tail_reg    <= '0;
            left_reg    <= '0;
            hdr_cnt_reg <= '0;
            pf_pend_reg <= 1'b0;
        end
        else
        begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            left_reg    <= left_next;
            hdr_cnt_reg <= hdr_cnt_next;
            pf_pend_reg <= pf_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pf_pend_reg)
        begin
            hdr_reg[hdr_cnt_reg[lfrb_pkg::HDR_IDX_W-1:0]] <= rd_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/lfrb_out.sv -----
`default_nettype none

module lfrb_out (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           issue,
    input  wire lfrb_pkg::result_t              res,
    input  wire logic [lfrb_pkg::BYTE_W-1:0]    rd_data,
    output logic                                pipe_ready,
    output logic                                rd_busy,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output lfrb_pkg::status_t                   status,
    output logic [lfrb_pkg::BYTE_W-1:0]         data_byte,
    output logic                                last_byte,
    output logic [lfrb_pkg::OUT_CNT_W-1:0]      used_count,
    output logic [lfrb_pkg::OUT_CNT_W-1:0]      free_space
);

    logic              s1_valid_reg;
    lfrb_pkg::result_t s1_res_reg;
    logic              out_valid_reg;
    lfrb_pkg::status_t status_reg;
    logic [lfrb_pkg::BYTE_W-1:0]    data_reg;
    logic                           last_reg;
    logic [lfrb_pkg::OUT_CNT_W-1:0] used_reg;
    logic [lfrb_pkg::OUT_CNT_W-1:0] free_reg;
    logic out_free;
    lfrb_pkg::ptr_t free_ptr;

    assign out_free   = !out_valid_reg || out_ready;
    assign pipe_ready = !s1_valid_reg || out_free;
    // Read data belongs to the item in this stage until it moves on
    assign rd_busy    = s1_valid_reg && s1_res_reg.give;
    assign free_ptr   = lfrb_pkg::PTR_LAST - s1_res_reg.used;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pipe_ready)
            begin
                s1_valid_reg <= issue;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue && pipe_ready)
        begin
            s1_res_reg <= res;
        end
        if (s1_valid_reg && out_free)
        begin
            status_reg <= s1_res_reg.status;
            data_reg   <= s1_res_reg.give ? rd_data : '0;
            last_reg   <= s1_res_reg.last;
            used_reg   <= lfrb_pkg::OUT_CNT_W'(s1_res_reg.used);
            free_reg   <= lfrb_pkg::OUT_CNT_W'(free_ptr);
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign data_byte  = data_reg;
    assign last_byte  = last_reg;
    assign used_count = used_reg;
    assign free_space = free_reg;

endmodule

`default_nettype wire

// ----- rtl/core/length_prefixed_frame_ring_buffer_unit.sv -----
// Channel   Handshake              Payload
// input     in_valid / in_ready    op, in_byte
// output    out_valid / out_ready  status, data_byte, last_byte, used_count, free_space
//
// One item a cycle unless the output stalls or a pull waits for its header; a result
// passes the read stage and the result register before it is offered. A pull at the
// start of a frame waits while the 4 length bytes are fetched from the ring memory
// through its single read port, one byte at a time, once the previous frame's last
// byte is taken; while the output stalls, the read port stays with a given byte.
// Reset clears pointers, counters and valid flags only; the ring memory is not cleared.
// A stalled output holds the result register and one item in the read stage.
`default_nettype none

module length_prefixed_frame_ring_buffer_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            op,
    input  wire logic [lfrb_pkg::BYTE_W-1:0]     in_byte,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [lfrb_pkg::STATUS_W-1:0]        status,
    output logic [lfrb_pkg::BYTE_W-1:0]          data_byte,
    output logic                                 last_byte,
    output logic [lfrb_pkg::OUT_CNT_W-1:0]       used_count,
    output logic [lfrb_pkg::OUT_CNT_W-1:0]       free_space
);

    logic              issue;
    logic              pipe_ready;
    logic              rd_busy;
    lfrb_pkg::result_t res;
    logic              wr_en;
    lfrb_pkg::ptr_t    wr_addr;
    logic [lfrb_pkg::BYTE_W-1:0] wr_data;
    logic              rd_en;
    lfrb_pkg::ptr_t    rd_addr;
    logic [lfrb_pkg::BYTE_W-1:0] rd_data;
    lfrb_pkg::status_t status_e;

    lfrb_ram #(
        .DEPTH  (lfrb_pkg::RING_DEPTH),
        .WIDTH  (lfrb_pkg::BYTE_W),
        .ADDR_W (lfrb_pkg::PTR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    lfrb_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (lfrb_pkg::op_t'(op)),
        .in_byte    (in_byte),
        .pipe_ready (pipe_ready),
        .rd_busy    (rd_busy),
        .issue      (issue),
        .res        (res),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

    lfrb_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .issue      (issue),
        .res        (res),
        .rd_data    (rd_data),
        .pipe_ready (pipe_ready),
        .rd_busy    (rd_busy),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status_e),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .used_count (used_count),
        .free_space (free_space)
    );

    assign status = status_e;

endmodule

`default_nettype wire
